>>> sv/ebd_pkg.sv
// Shared types and constants for the binary erosion and boundary core.
// Holds configuration register codes, reset values and the window cell types.
// No dependencies.
package ebd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_MASK_DEF  = 15;

    localparam int PIX_W      = 8;
    localparam int MASK_CFG_W = 4;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = DIM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int THR_RST    = 200;
    localparam int MASK_RST   = 3;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_MASK      = 3'd1,
        CFG_WIDTH     = 3'd2,
        CFG_HEIGHT    = 3'd3
    } t_cfg_idx;

    // One pixel as it travels along the window chain.
    typedef struct packed {
        logic vert_white;    // whole vertical span of the mask is white
        logic center_white;  // thresholded bit of the output row in this column
    } t_cell;

    // Per-cell selection derived from the current mask size.
    typedef struct packed {
        logic in_window;     // cell lies inside the horizontal span
        logic tap;           // cell holds the center pixel of the output
    } t_cell_ctl;

endpackage

>>> sv/ebd_cell.sv
// One cell of the horizontal window chain of the erosion core.
// Holds one pixel and folds it into the window AND and the center select.
// Depends on ebd_pkg.
module ebd_cell
    import ebd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_shift,
    input  t_cell     i_d,
    input  t_cell_ctl i_ctl,
    input  logic      i_and,
    input  logic      i_center,
    output t_cell     o_q,
    output logic      o_and,
    output logic      o_center
);

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q      = r_q;
    assign o_and    = i_and & (r_q.vert_white | ~i_ctl.in_window);
    assign o_center = i_center | (r_q.center_white & i_ctl.tap);

endmodule

>>> sv/ebd_column_store.sv
// Per-column line store of the erosion core: vertical white run and row history.
// Read-modify-write of one column per word, with write forwarding.
// Depends on ebd_pkg.
module ebd_column_store
    import ebd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_MASK  = MAX_MASK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic                          i_white,
    input  logic                          i_first_row,
    input  logic [$clog2(MAX_MASK+1)-1:0] i_mask,
    input  logic [$clog2(MAX_MASK+1)-1:0] i_after,
    output t_cell                         o_cell
);

    localparam int MASK_W  = $clog2(MAX_MASK + 1);
    localparam int RUN_W   = MASK_W;
    localparam int HIST_W  = (MAX_MASK + 1) / 2 - 1;
    localparam int ENTRY_W = RUN_W + HIST_W;

    logic [ENTRY_W-1:0] r_mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_mem_q;
    logic [ENTRY_W-1:0] r_fwd_q;
    logic               r_fwd;

    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] n_entry;
    logic [RUN_W-1:0]   prev_run;
    logic [RUN_W-1:0]   n_run;
    logic [HIST_W-1:0]  hist;
    logic [HIST_W-1:0]  n_hist;
    logic               center;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= n_entry;
        end
    end

    // The word being written back may be the one read next (narrow frames).
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_rd_addr];
            r_fwd   <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_q <= n_entry;
        end
    end

    always_comb begin
        entry    = r_fwd ? r_fwd_q : r_mem_q;
        hist     = entry[HIST_W-1:0];
        prev_run = i_first_row ? '0 : entry[ENTRY_W-1 -: RUN_W];
        if (!i_white) begin
            n_run = '0;
        end else if (prev_run == RUN_W'(MAX_MASK)) begin
            n_run = prev_run;
        end else begin
            n_run = prev_run + RUN_W'(1);
        end
        n_hist  = HIST_W'({hist, i_white});
        n_entry = {n_run, n_hist};

        center = i_white;
        for (int j = 0; j < HIST_W; j++) begin
            if (i_after == MASK_W'(j + 1)) begin
                center = hist[j];
            end
        end
    end

    assign o_cell.vert_white   = (n_run >= i_mask);
    assign o_cell.center_white = center;

endmodule

>>> sv/binary_erosion_boundary_core.sv
// Binary erosion and boundary extraction over a raster pixel stream.
// One word per cycle in and out when no stall holds it. A result is registered
// in the column stage, then the output register, after the word that completes
// its window, mask_after lines and pixels later; drain words flush the last ones.
// Reset restores the default registers and clears all counters and valids at once;
// the column store is not swept, since the first line of a frame ignores its run.
module binary_erosion_boundary_core
    import ebd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_MASK  = MAX_MASK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Pixel input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [PIX_W-1:0]      i_pixel_value,
    // Result output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_thresholded_white,
    output logic                  o_eroded_white,
    output logic                  o_boundary_white,
    output logic                  o_end_of_line,
    output logic                  o_last_of_frame,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
    localparam int MASK_W    = $clog2(MAX_MASK + 1);
    localparam int CHAIN_N   = MAX_MASK - 1;
    localparam int WIDTH_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int AFTER_RST = MASK_RST - 1 - MASK_RST / 2;

    // Control bits of one word, worked out when it is accepted.
    typedef struct packed {
        logic white;      // thresholded pixel inside the frame
        logic first_row;  // first line: nothing above counts
        logic col_full;   // mask span fits left of this column
        logic emit;       // this word completes a result
        logic eol;        // that result closes a line
        logic last;       // that result closes the frame
    } t_ctrl;

    // Configuration registers, kept in their effective (clamped) form.
    logic [PIX_W-1:0]   r_thr;
    logic [MASK_W-1:0]  r_mask;
    logic [MASK_W-1:0]  r_after;
    logic [WIDTH_W-1:0] r_width;
    logic [DIM_W-1:0]   r_height;

    // Stream position counters.
    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_out_col;
    logic [DIM_W-1:0]   r_out_row;
    logic [MASK_W-1:0]  r_lead;
    logic [COL_W-1:0]   n_in_col;
    logic [ROW_W-1:0]   n_in_row;
    logic [COL_W-1:0]   n_out_col;
    logic [DIM_W-1:0]   n_out_row;
    logic [MASK_W-1:0]  n_lead;

    // Column-store stage.
    logic               r_b_valid;
    t_ctrl              r_b_ctrl;
    logic [COL_W-1:0]   r_b_col;

    // Output register.
    logic               r_out_valid;
    logic               r_out_thr;
    logic               r_out_ero;
    logic               r_out_eol;
    logic               r_out_last;

    logic               cfg_we;
    logic               cfg_known;
    logic [MASK_CFG_W-1:0] cfg_mask_raw;
    logic [DIM_W-1:0]   cfg_dim_raw;
    logic [MASK_W-1:0]  n_mask_cfg;
    logic [MASK_W-1:0]  n_after_cfg;
    logic [WIDTH_W-1:0] n_width_cfg;
    logic [DIM_W-1:0]   n_height_cfg;

    logic               in_accept;
    logic               out_free;
    logic               b_advance;
    logic               row_lead;
    logic               lead_done;
    logic [COL_W-1:0]   last_col;
    t_ctrl              a_ctrl;

    t_cell              new_cell;
    t_cell              cell_d   [CHAIN_N];
    t_cell              cell_q   [CHAIN_N];
    t_cell_ctl          cell_ctl [CHAIN_N];
    logic               and_link    [CHAIN_N+1];
    logic               center_link [CHAIN_N+1];

    // ------------------------------------------------------------------
    // Configuration. Writes are always taken; a known register index also
    // restarts the frame.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_THRESHOLD, CFG_MASK, CFG_WIDTH, CFG_HEIGHT: cfg_known = 1'b1;
            default:                                        cfg_known = 1'b0;
        endcase
    end

    // A zero size acts as one, and sizes past the build limits are clamped.
    always_comb begin
        cfg_mask_raw = i_cfg_data[MASK_CFG_W-1:0];
        cfg_dim_raw  = i_cfg_data[DIM_W-1:0];
        if (cfg_mask_raw == '0) begin
            n_mask_cfg = MASK_W'(1);
        end else if (cfg_mask_raw > MAX_MASK) begin
            n_mask_cfg = MASK_W'(MAX_MASK);
        end else begin
            n_mask_cfg = MASK_W'(cfg_mask_raw);
        end
        n_after_cfg = n_mask_cfg - MASK_W'(1) - (n_mask_cfg >> 1);
        if (cfg_dim_raw == '0) begin
            n_width_cfg = WIDTH_W'(1);
        end else if (cfg_dim_raw > MAX_WIDTH) begin
            n_width_cfg = WIDTH_W'(MAX_WIDTH);
        end else begin
            n_width_cfg = WIDTH_W'(cfg_dim_raw);
        end
        n_height_cfg = (cfg_dim_raw == '0) ? DIM_W'(1) : cfg_dim_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= PIX_W'(THR_RST);
            r_mask   <= MASK_W'(MASK_RST);
            r_after  <= MASK_W'(AFTER_RST);
            r_width  <= WIDTH_W'(WIDTH_RST_EFF);
            r_height <= DIM_W'(HEIGHT_RST);
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_thr <= i_cfg_data[PIX_W-1:0];
                CFG_MASK: begin
                    r_mask  <= n_mask_cfg;
                    r_after <= n_after_cfg;
                end
                CFG_WIDTH:  r_width  <= n_width_cfg;
                CFG_HEIGHT: r_height <= n_height_cfg;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The output register frees the column stage whenever it is
    // empty or being taken, and words that complete no result pass straight
    // through the column stage without touching it.
    // ------------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign b_advance  = r_b_valid && (!r_b_ctrl.emit || out_free);
    assign o_in_stall = r_b_valid && !b_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Accept stage: threshold the pixel and place the word in the frame.
    // A result is due once the stream is mask_after lines plus mask_after
    // pixels ahead of it; r_lead counts the pixels past the line part.
    // ------------------------------------------------------------------
    assign last_col  = COL_W'(r_width - WIDTH_W'(1));
    assign row_lead  = (r_in_row >= ROW_W'(r_after));
    assign lead_done = (r_lead == r_after);

    always_comb begin
        a_ctrl.white     = !i_func && (r_in_row < ROW_W'(r_height)) &&
                           (i_pixel_value > r_thr);
        a_ctrl.first_row = (r_in_row == '0);
        a_ctrl.col_full  = (r_in_col >= COL_W'(r_mask - MASK_W'(1)));
        a_ctrl.emit      = row_lead && lead_done;
        a_ctrl.eol       = (r_out_col == last_col);
        a_ctrl.last      = a_ctrl.eol && (r_out_row == r_height - DIM_W'(1));
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        if (cfg_we && cfg_known) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end else if (in_accept) begin
            if (a_ctrl.emit && a_ctrl.last) begin
                // The frame's final result: the next word opens a new frame.
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_lead    = '0;
            end else begin
                if (r_in_col == last_col) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
                if (row_lead && !lead_done) begin
                    n_lead = r_lead + MASK_W'(1);
                end
                if (a_ctrl.emit) begin
                    if (a_ctrl.eol) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + DIM_W'(1);
                    end else begin
                        n_out_col = r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
        end
    end

    // ------------------------------------------------------------------
    // Column stage: the store's read data arrives here, the column's
    // vertical run and row history are updated and written back.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_accept) begin
            r_b_valid <= 1'b1;
        end else if (b_advance) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_ctrl <= a_ctrl;
            r_b_col  <= r_in_col;
        end
    end

    ebd_column_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_MASK  (MAX_MASK)
    ) u_column_store (
        .i_clk       (i_clk),
        .i_rd_en     (in_accept),
        .i_rd_addr   (r_in_col),
        .i_wr_en     (b_advance),
        .i_wr_addr   (r_b_col),
        .i_white     (r_b_ctrl.white),
        .i_first_row (r_b_ctrl.first_row),
        .i_mask      (r_mask),
        .i_after     (r_after),
        .o_cell      (new_cell)
    );

    // ------------------------------------------------------------------
    // Window chain. Cell j holds the word that came j+1 words before the
    // one in the column stage. The AND ripples over the cells inside the
    // mask span, and the center bit is picked from the cell mask_after
    // words back (or from the new word when mask_after is zero).
    // ------------------------------------------------------------------
    assign and_link[0]    = new_cell.vert_white & r_b_ctrl.col_full;
    assign center_link[0] = (r_after == '0) & new_cell.center_white;

    for (genvar j = 0; j < CHAIN_N; j++) begin : g_chain
        if (j == 0) begin : g_head
            assign cell_d[j] = new_cell;
        end else begin : g_link
            assign cell_d[j] = cell_q[j-1];
        end
        assign cell_ctl[j].in_window = (r_mask > MASK_W'(j + 1));
        assign cell_ctl[j].tap       = (r_after == MASK_W'(j + 1));

        ebd_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (b_advance),
            .i_d      (cell_d[j]),
            .i_ctl    (cell_ctl[j]),
            .i_and    (and_link[j]),
            .i_center (center_link[j]),
            .o_q      (cell_q[j]),
            .o_and    (and_link[j+1]),
            .o_center (center_link[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_advance && r_b_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance && r_b_ctrl.emit) begin
            r_out_thr  <= center_link[CHAIN_N];
            r_out_ero  <= and_link[CHAIN_N];
            r_out_eol  <= r_b_ctrl.eol;
            r_out_last <= r_b_ctrl.last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_thresholded_white = r_out_thr;
    assign o_eroded_white      = r_out_ero;
    assign o_boundary_white    = r_out_thr & ~r_out_ero;
    assign o_end_of_line       = r_out_eol;
    assign o_last_of_frame     = r_out_last;

endmodule

>>> dv/tb_binary_erosion_boundary_core.sv
// Self-checking testbench for binary_erosion_boundary_core.
// Drives random and directed pixel words, predicts every result word in a local
// model of the thresholding and erosion, and depends only on ebd_pkg and the core.
module tb_binary_erosion_boundary_core;
    import ebd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LINES      = MAX_MASK_DEF + 1;
    localparam int IDLE_PCT        = 26;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 40;
    // Any index past the register list; the core must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_HEIGHT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP   = {CFG_IDX_W{1'b1}};

    // Flags of one output pixel, in the order they appear on the ports.
    typedef struct packed {
        logic thresholded;
        logic eroded;
        logic boundary;
        logic eol;
        logic lof;
    } t_pixel_flags;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_func = 1'b0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_thresholded_white;
    logic                  o_eroded_white;
    logic                  o_boundary_white;
    logic                  o_end_of_line;
    logic                  o_last_of_frame;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    binary_erosion_boundary_core dut (.*);

    // Local copy of the core's registers and frame position.
    logic [PIX_W-1:0]      cur_threshold;
    logic [MASK_CFG_W-1:0] cur_mask;
    logic [DIM_W-1:0]      cur_width;
    logic [DIM_W-1:0]      cur_height;
    int                    next_col;
    int                    next_row;
    int                    results_in_frame;
    // Ring of recent binary lines, indexed by row modulo the ring depth.
    bit                    line_ring [RING_LINES][MAX_WIDTH_DEF];

    // Output pixels predicted but not yet seen, oldest first.
    t_pixel_flags          awaited_pixels [$];

    int                    errors = 0;
    int                    words_accepted = 0;
    bit                    idle_on = 1'b1;
    int                    hold_off_request = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Effective frame size and mask after the core's clamping rules: a zero
    // width, height or mask acts as one and a width past the line store is cut.
    function automatic void frame_geometry(output int w, output int h, output int m);
        w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : int'(cur_width));
        h = (cur_height == 0) ? 1 : int'(cur_height);
        m = (cur_mask == 0) ? 1 : (cur_mask > MAX_MASK_DEF ? MAX_MASK_DEF : int'(cur_mask));
    endfunction

    // Words in one complete frame: the pixels themselves, then the flush words
    // that push the last output pixels out.
    function automatic void frame_words(output int pixels, output int flush);
        int w, h, m, lag;
        frame_geometry(w, h, m);
        lag = m - 1 - m / 2;
        pixels = w * h;
        flush = lag * w + lag;
    endfunction

    function automatic void restart_frame_count();
        next_col = 0;
        next_row = 0;
        results_in_frame = 0;
    endfunction

    // Anything outside the frame reads as black.
    function automatic bit ring_bit(int row, int col, int w, int h);
        if (row < 0 || col < 0 || row >= h || col >= w) return 1'b0;
        return line_ring[row % RING_LINES][col];
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_THRESHOLD: cur_threshold = data[PIX_W-1:0];
            CFG_MASK:      cur_mask = data[MASK_CFG_W-1:0];
            CFG_WIDTH:     cur_width = data[DIM_W-1:0];
            CFG_HEIGHT:    cur_height = data[DIM_W-1:0];
            default:       return;
        endcase
        // Every real register write starts a new frame.
        restart_frame_count();
    endfunction

    // Stores the binary pixel of one accepted word and, once the window of the
    // oldest pending output pixel is complete, queues that pixel's flags.
    function automatic void erode_word(bit drain, logic [PIX_W-1:0] value);
        int w, h, m, lead, lag, total, lat, pos, k, r, c, dy, dx;
        bit white, thr, ero;
        t_pixel_flags res;
        frame_geometry(w, h, m);
        lead = m / 2;
        lag = m - 1 - lead;
        total = w * h;
        lat = lag * w + lag;
        if (next_col >= w) next_col = 0;
        pos = next_row * w + next_col;
        // Drain words and anything past the frame's pixels are black.
        white = !drain && pos < total && value > cur_threshold;
        line_ring[next_row % RING_LINES][next_col] = white;
        next_col++;
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (pos < lat) return;

        k = results_in_frame;
        r = k / w;
        c = k % w;
        thr = ring_bit(r, c, w, h);
        ero = 1'b1;
        for (dy = 0; dy < m; dy++) begin
            for (dx = 0; dx < m; dx++) begin
                if (!ring_bit(r + dy - lead, c + dx - lead, w, h)) ero = 1'b0;
            end
        end
        res.thresholded = thr;
        res.eroded = ero;
        res.boundary = thr && !ero;
        res.eol = (c == w - 1);
        res.lof = (k + 1 >= total);
        awaited_pixels.push_back(res);
        results_in_frame++;
        if (k + 1 >= total) restart_frame_count();
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Every task below is entered right after a rising edge and returns right
    // after one, so all drives land at the edge through nonblocking assignments.

    // Offers one pixel word, with random idle cycles first, and waits until the
    // core takes it.
    task automatic push_word(bit drain, logic [PIX_W-1:0] value);
        i_cfg_valid <= 1'b0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= drain;
        i_pixel_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        words_accepted++;
        erode_word(drain, value);
    endtask

    // Register writes are only issued from idle, after wait_idle or another write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    // Lets every predicted pixel arrive, then gives the core time to settle
    // words that have not produced an output yet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly white pixels, so that the erosion keeps some of them.
    function automatic logic [PIX_W-1:0] pick_pixel();
        if (cur_threshold != 8'hFF && $urandom_range(0, 99) < 80)
            return PIX_W'($urandom_range(255, int'(cur_threshold) + 1));
        return PIX_W'($urandom_range(0, int'(cur_threshold)));
    endfunction

    // Frame pixels; now and then an early drain word stands in for a black pixel.
    task automatic send_frame_pixels(int count);
        repeat (count) push_word($urandom_range(0, 19) == 0, pick_pixel());
    endtask

    // Flush words; some are ordinary pixel words, which count as border anyway.
    task automatic send_flush(int count);
        repeat (count) push_word($urandom_range(0, 3) != 0, PIX_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A few words under the reset settings; the 640x480 frame never reaches
    // its first output, and the next register write discards it.
    task automatic test_reset_settings();
        repeat (3) push_word(1'b0, pick_pixel());
    endtask

    // One-pixel frames: zero width, height and mask all act as one, so every
    // word yields its own pixel with end of line and end of frame set.
    task automatic test_single_pixel_frames();
        wait_idle();
        write_reg(CFG_THRESHOLD, 11'h700);   // upper bits drop, threshold 0
        write_reg(CFG_MASK, 11'd0);
        write_reg(CFG_WIDTH, 11'd0);
        write_reg(CFG_HEIGHT, 11'd0);
        push_word(1'b0, 8'd0);
        push_word(1'b0, 8'd1);
        push_word(1'b0, 8'd255);
        push_word(1'b1, 8'd255);             // drain word is black
        wait_idle();
        write_reg(CFG_THRESHOLD, 11'h0FF);   // nothing is above 255
        push_word(1'b0, 8'd255);
        push_word(1'b0, 8'd128);
    endtask

    // A 3x2 frame under a 3x3 mask, with an early drain word inside the frame,
    // pixel words among the flush words and an ignored write to a spare index
    // part way through the frame.
    task automatic test_small_window_frame();
        wait_idle();
        write_reg(CFG_THRESHOLD, 11'd200);
        write_reg(CFG_MASK, 11'd3);
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'd2);
        push_word(1'b0, 8'd255);
        push_word(1'b0, 8'd255);
        wait_idle();
        write_reg(CFG_SPARE, 11'h7FF);
        push_word(1'b1, 8'd255);
        push_word(1'b0, 8'd201);
        push_word(1'b0, 8'd255);
        push_word(1'b0, 8'd200);
        push_word(1'b1, 8'd0);
        push_word(1'b0, 8'd255);
        push_word(1'b1, 8'd255);
        push_word(1'b0, 8'd128);
    endtask

    // An even mask has its window above and left of the pixel and no flush at all.
    task automatic test_even_mask_frame();
        wait_idle();
        write_reg(CFG_MASK, 11'h7F2);        // upper bits drop, mask 2
        write_reg(CFG_WIDTH, 11'd2);
        write_reg(CFG_HEIGHT, 11'd2);
        repeat (4) push_word(1'b0, 8'd255);
    endtask

    // The receiver holds off for a long stretch while the sender keeps going,
    // so the core fills up and must stall its input.
    task automatic test_output_hold_off();
        int pixels, flush;
        wait_idle();
        write_reg(CFG_THRESHOLD, 11'd128);
        write_reg(CFG_MASK, 11'd3);
        write_reg(CFG_WIDTH, 11'd16);
        write_reg(CFG_HEIGHT, 11'd8);
        frame_words(pixels, flush);
        idle_on = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        send_frame_pixels(pixels);
        send_flush(flush);
        idle_on = 1'b1;
    endtask

    // The widest line: a width past the line store is cut to the store size.
    task automatic test_widest_line();
        int pixels, flush;
        wait_idle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom));
        write_reg(CFG_MASK, 11'd1);
        write_reg(CFG_WIDTH, 11'h7FF);
        write_reg(CFG_HEIGHT, 11'd1);
        frame_words(pixels, flush);
        send_frame_pixels(pixels);
    endtask

    // The largest mask on the tallest frame; the frame is cut short and the
    // next register write restarts it.
    task automatic test_tall_frame_largest_mask();
        wait_idle();
        write_reg(CFG_THRESHOLD, 11'd100);
        write_reg(CFG_MASK, 11'd15);
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'h7FF);
        send_frame_pixels(40);
    endtask

    // Random frame shapes and contents. Most frames are complete; some are cut
    // short and some are plain noise, and both are followed by a restart.
    task automatic test_random_frames(int budget);
        int start, done, pixels, flush, roll, n;
        bit restart_due;
        start = words_accepted;
        restart_due = 1'b1;
        while (words_accepted - start < budget) begin
            done = words_accepted - start;
            // The middle third runs with no idling on either side.
            idle_on = !(done > budget / 3 && done < 2 * budget / 3);
            wait_idle();
            // A finished frame may simply be followed by the next one, which
            // checks the core's own return to the start of a frame.
            if (restart_due || $urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 1)) write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 99) < 60)
                    n = $urandom_range(0, 5);
                else
                    n = $urandom_range(0, 15);
                write_reg(CFG_MASK, CFG_DATA_W'(n | ($urandom_range(0, 127) << MASK_CFG_W)));
                write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, 16)));
                write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 10)));
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE, CFG_TOP)),
                              CFG_DATA_W'($urandom));
            end
            frame_words(pixels, flush);
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                send_frame_pixels(pixels);
                send_flush(flush);
                restart_due = 1'b0;
            end else if (roll < 90) begin
                n = $urandom_range(1, pixels + flush);
                if (n <= pixels) begin
                    send_frame_pixels(n);
                end else begin
                    send_frame_pixels(pixels);
                    send_flush(n - pixels);
                end
                restart_due = 1'b1;
            end else begin
                repeat ($urandom_range(1, 8)) push_word($urandom_range(0, 1), PIX_W'($urandom));
                restart_due = 1'b1;
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------

    // Random stall, or a long counted hold-off when a test asks for one.
    initial begin : out_stall_driver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_request != 0) begin
                n = hold_off_request;
                hold_off_request = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic void check_field(string name, logic want, logic got);
        if (got !== want) begin
            if (errors < MAX_REPORTS)
                $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endfunction

    // Values read right after the edge are the ones the edge sampled.
    initial begin : result_compare
        t_pixel_flags want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (awaited_pixels.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $error("result word arrived with no pixel expected");
                    errors++;
                end else begin
                    want = awaited_pixels.pop_front();
                    check_field("thresholded_white", want.thresholded, o_thresholded_white);
                    check_field("eroded_white", want.eroded, o_eroded_white);
                    check_field("boundary_white", want.boundary, o_boundary_white);
                    check_field("end_of_line", want.eol, o_end_of_line);
                    check_field("last_of_frame", want.lof, o_last_of_frame);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[binary_erosion_boundary_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : test_sequence
        cur_threshold = PIX_W'(THR_RST);
        cur_mask = MASK_CFG_W'(MASK_RST);
        cur_width = DIM_W'(WIDTH_RST);
        cur_height = DIM_W'(HEIGHT_RST);
        foreach (line_ring[r, c]) line_ring[r][c] = 1'b0;
        restart_frame_count();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_single_pixel_frames();
        test_small_window_frame();
        test_even_mask_frame();
        test_output_hold_off();
        test_widest_line();
        test_tall_frame_largest_mask();
        test_random_frames(220);

        wait_idle();
        if (errors == 0) begin
            $display("[binary_erosion_boundary_core] OK");
        end else begin
            $display("[binary_erosion_boundary_core] ERROR");
        end
        $finish;
    end

endmodule
